// File: design/ppg_pkg.sv
// Shared package for the pixel-to-ground projection block.
// Holds register codes, reset values, fixed-point constants and width helpers.
// No dependencies.
package ppg_pkg;

  localparam int unsigned PIXEL_BITS_DEF = 12;
  localparam int unsigned COORD_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 48;
  localparam int unsigned FINV_W         = 24;
  localparam int unsigned RAY_FRAC       = 28;
  localparam int unsigned DIV_SHIFT      = 16;
  localparam int unsigned HORIZON_SHIFT  = 18;
  localparam int unsigned RANGE_LIMIT    = 12764;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_X   = 3'd0,
    REG_ROT_Y   = 3'd1,
    REG_ROT_Z   = 3'd2,
    REG_CAM_POS = 3'd3,
    REG_OPT_CTR = 3'd4,
    REG_FOC_INV = 3'd5
  } cfg_reg_e;

  localparam logic [47:0] ROT_X_RST   = 48'd16384;
  localparam logic [47:0] ROT_Y_RST   = 48'd1073741824;
  localparam logic [47:0] ROT_Z_RST   = 48'd70368744177664;
  localparam logic [47:0] CAM_POS_RST = 48'd2147483648000;
  localparam logic [31:0] OPT_CTR_RST = 32'd251663360;
  localparam logic [23:0] FOC_INV_RST = 24'd33554;

  typedef struct packed {
    logic [47:0] rot_x;
    logic [47:0] rot_y;
    logic [47:0] rot_z;
    logic [47:0] cam_pos;
    logic [31:0] opt_ctr;
    logic [23:0] finv;
  } ppg_cfg_t;

  // Width of the Q.4 pixel offset from the optical center.
  function automatic int ppg_dx_w(input int pb);
    return (((pb + 4) > 16) ? (pb + 4) : 16) + 1;
  endfunction

  // Width of the world vector after the floor shift (divisor width).
  function automatic int ppg_den_w(input int pb);
    return ppg_dx_w(pb) + 27;
  endfunction

  // Width of the division numerator.
  function automatic int ppg_num_w(input int pb);
    return ppg_den_w(pb) + 17;
  endfunction

  // Quotient bits kept: enough for saturation and the range test.
  function automatic int ppg_quo_w(input int cb);
    return (cb > 15) ? cb : 15;
  endfunction

endpackage

// File: design/ppg_rotate.sv
// Ray forming, rotation, horizon test and division numerator pipeline.
// Six register stages; depends on ppg_pkg.
module ppg_rotate #(
  parameter int unsigned PIXEL_BITS = ppg_pkg::PIXEL_BITS_DEF,
  parameter int unsigned DEN_W      = ppg_pkg::ppg_den_w(ppg_pkg::PIXEL_BITS_DEF),
  parameter int unsigned NUM_W      = ppg_pkg::ppg_num_w(ppg_pkg::PIXEL_BITS_DEF)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ppg_pkg::ppg_cfg_t       cfg_i,
  input  logic                    valid_i,
  input  logic [PIXEL_BITS-1:0]   pixel_x_i,
  input  logic [PIXEL_BITS-1:0]   pixel_y_i,
  output logic                    valid_o,
  output logic                    above_o,
  output logic signed [NUM_W-1:0] num_x_o,
  output logic signed [NUM_W-1:0] num_y_o,
  output logic signed [DEN_W-1:0] den_o
);
  import ppg_pkg::*;

  localparam int unsigned DXW = ppg_dx_w(PIXEL_BITS);
  localparam int unsigned VW  = DXW + FINV_W + 1;
  localparam int unsigned PW  = VW + 16;
  localparam int unsigned WW  = PW + 2;
  localparam int unsigned TW  = DEN_W + 16;

  logic [5:0] vld_q;

  // Stage 1: offsets from the optical center
  logic signed [DXW-1:0] dx_d, dy_d, dx_q, dy_q;
  // Stage 2: camera ray
  logic signed [VW-1:0]  v1_d, v2_d, v1_q, v2_q;
  // Stage 3: matrix products, row-major
  logic signed [PW-1:0]  p_d [3][3];
  logic signed [PW-1:0]  p_q [3][3];
  // Stage 4: world ray
  logic signed [WW-1:0]  w_d [3];
  logic signed [WW-1:0]  w_q [3];
  // Stage 5: horizon flag and cross products
  logic signed [WW-1:0]  lim;
  logic [FINV_W+2:0]     f5;
  logic signed [DEN_W-1:0] sx, sy, sz;
  logic signed [15:0]    tx, ty, tz;
  logic signed [TW-1:0]  txsz_d, tysz_d, tzsx_d, tzsy_d;
  logic signed [TW-1:0]  txsz_q, tysz_q, tzsx_q, tzsy_q;
  logic                  above_d, above5_q, above6_q;
  logic signed [DEN_W-1:0] sz5_q, sz6_q;
  logic signed [NUM_W-1:0] nx_d, ny_d, nx_q, ny_q;
  logic [47:0]           rows [3];

  assign rows[0] = cfg_i.rot_x;
  assign rows[1] = cfg_i.rot_y;
  assign rows[2] = cfg_i.rot_z;

  assign dx_d = $signed({{(DXW-16){1'b0}}, cfg_i.opt_ctr[15:0]})
              - $signed({{(DXW-PIXEL_BITS-4){1'b0}}, pixel_x_i, 4'b0000});
  assign dy_d = $signed({{(DXW-16){1'b0}}, cfg_i.opt_ctr[31:16]})
              - $signed({{(DXW-PIXEL_BITS-4){1'b0}}, pixel_y_i, 4'b0000});

  assign v1_d = dx_q * $signed({1'b0, cfg_i.finv});
  assign v2_d = dy_q * $signed({1'b0, cfg_i.finv});

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p_d[k][0] = $signed({{(PW-16-RAY_FRAC){rows[k][15]}}, rows[k][15:0],
                           {RAY_FRAC{1'b0}}});
      p_d[k][1] = $signed(rows[k][31:16]) * v1_q;
      p_d[k][2] = $signed(rows[k][47:32]) * v2_q;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w_d[k] = WW'(p_q[k][0]) + WW'(p_q[k][1]) + WW'(p_q[k][2]);
    end
  end

  // Horizon limit is -5 * F scaled to 42 fraction bits
  assign f5  = {1'b0, cfg_i.finv, 2'b00} + {3'b000, cfg_i.finv};
  assign lim = -$signed({{(WW-FINV_W-3-HORIZON_SHIFT){1'b0}}, f5,
                         {HORIZON_SHIFT{1'b0}}});
  assign above_d = (w_q[2] > lim) || (w_q[2] == '0);

  // Dropping low bits of two's complement floors toward minus infinity
  assign sx = w_q[0][WW-1:DIV_SHIFT];
  assign sy = w_q[1][WW-1:DIV_SHIFT];
  assign sz = w_q[2][WW-1:DIV_SHIFT];
  assign tx = $signed(cfg_i.cam_pos[15:0]);
  assign ty = $signed(cfg_i.cam_pos[31:16]);
  assign tz = $signed(cfg_i.cam_pos[47:32]);

  assign txsz_d = tx * sz;
  assign tysz_d = ty * sz;
  assign tzsx_d = tz * sx;
  assign tzsy_d = tz * sy;

  assign nx_d = NUM_W'(txsz_q) - NUM_W'(tzsx_q);
  assign ny_d = NUM_W'(tysz_q) - NUM_W'(tzsy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    v1_q     <= v1_d;
    v2_q     <= v2_d;
    p_q      <= p_d;
    w_q      <= w_d;
    above5_q <= above_d;
    sz5_q    <= sz;
    txsz_q   <= txsz_d;
    tysz_q   <= tysz_d;
    tzsx_q   <= tzsx_d;
    tzsy_q   <= tzsy_d;
    above6_q <= above5_q;
    sz6_q    <= sz5_q;
    nx_q     <= nx_d;
    ny_q     <= ny_d;
  end

  assign valid_o = vld_q[5];
  assign above_o = above6_q;
  assign num_x_o = nx_q;
  assign num_y_o = ny_q;
  assign den_o   = sz6_q;

endmodule

// File: design/ppg_div.sv
// Pipelined restoring divider, one quotient bit per stage, truncating toward zero.
// Gives magnitude, sign and an overflow flag; depends on ppg_pkg.
module ppg_div #(
  parameter int unsigned NUM_W = ppg_pkg::ppg_num_w(ppg_pkg::PIXEL_BITS_DEF),
  parameter int unsigned DEN_W = ppg_pkg::ppg_den_w(ppg_pkg::PIXEL_BITS_DEF),
  parameter int unsigned QUO_W = ppg_pkg::ppg_quo_w(ppg_pkg::COORD_BITS_DEF)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic                    tag_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic signed [DEN_W-1:0] den_i,
  output logic                    valid_o,
  output logic                    tag_o,
  output logic                    neg_o,
  output logic                    ovf_o,
  output logic [QUO_W-1:0]        quo_o
);
  import ppg_pkg::*;

  localparam int unsigned CW = NUM_W + QUO_W;

  // Entry stage: magnitudes and sign
  logic             va_q, ta_q, na_q;
  logic [NUM_W-1:0] nmag_d, nmag_q;
  logic [DEN_W-1:0] dmag_d, dmag_q;
  // Overflow stage
  logic             vb_q, tb_q, nb_q, ob_q;
  logic [NUM_W-1:0] rb_q;
  logic [DEN_W-1:0] db_q;
  logic             ovf_d;

  // Bit stages
  logic             vs_q [QUO_W];
  logic             ts_q [QUO_W];
  logic             ns_q [QUO_W];
  logic             os_q [QUO_W];
  logic [NUM_W-1:0] rs_q [QUO_W];
  logic [DEN_W-1:0] ds_q [QUO_W];
  logic [QUO_W-1:0] qs_q [QUO_W];

  assign nmag_d = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign dmag_d = den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
  assign ovf_d  = {{QUO_W{1'b0}}, nmag_q} >= CW'({dmag_q, {QUO_W{1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ta_q   <= tag_i;
    na_q   <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
    nmag_q <= nmag_d;
    dmag_q <= dmag_d;
    tb_q   <= ta_q;
    nb_q   <= na_q;
    ob_q   <= ovf_d;
    rb_q   <= nmag_q;
    db_q   <= dmag_q;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int unsigned BIT = QUO_W - 1 - k;
    logic             v_in, t_in, n_in, o_in;
    logic [NUM_W-1:0] r_in;
    logic [DEN_W-1:0] d_in;
    logic [QUO_W-1:0] q_in, q_nx;
    logic [CW-1:0]    trial;
    logic             take;
    logic [NUM_W-1:0] r_nx;

    if (k == 0) begin : g_first
      assign v_in = vb_q;
      assign t_in = tb_q;
      assign n_in = nb_q;
      assign o_in = ob_q;
      assign r_in = rb_q;
      assign d_in = db_q;
      assign q_in = '0;
    end else begin : g_next
      assign v_in = vs_q[k-1];
      assign t_in = ts_q[k-1];
      assign n_in = ns_q[k-1];
      assign o_in = os_q[k-1];
      assign r_in = rs_q[k-1];
      assign d_in = ds_q[k-1];
      assign q_in = qs_q[k-1];
    end

    assign trial = CW'({d_in}) << BIT;
    assign take  = {{QUO_W{1'b0}}, r_in} >= trial;
    assign r_nx  = take ? NUM_W'({{QUO_W{1'b0}}, r_in} - trial) : r_in;

    always_comb begin
      q_nx      = q_in;
      q_nx[BIT] = take;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[k] <= 1'b0;
      end else begin
        vs_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      ts_q[k] <= t_in;
      ns_q[k] <= n_in;
      os_q[k] <= o_in;
      rs_q[k] <= r_nx;
      ds_q[k] <= d_in;
      qs_q[k] <= q_nx;
    end
  end

  assign valid_o = vs_q[QUO_W-1];
  assign tag_o   = ts_q[QUO_W-1];
  assign neg_o   = ns_q[QUO_W-1];
  assign ovf_o   = os_q[QUO_W-1];
  assign quo_o   = qs_q[QUO_W-1];

endmodule

// File: design/pixel_to_ground_projection.sv
// Pixel-to-ground projection: pinhole ray, rotation, ground plane cut.
// The path runs through six rotation stages, two divider entry stages, one divider
// stage per quotient bit and one output stage. Throughput: one pixel per cycle;
// busy stays low. Reset clears all valid bits and loads the identity camera.
// Depends on ppg_pkg, ppg_rotate and ppg_div.
module pixel_to_ground_projection #(
  parameter int unsigned PIXEL_BITS = ppg_pkg::PIXEL_BITS_DEF,
  parameter int unsigned COORD_BITS = ppg_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // pixel transaction
  input  logic                                 start,
  output logic                                 busy,
  input  logic [PIXEL_BITS-1:0]                pixel_x_i,
  input  logic [PIXEL_BITS-1:0]                pixel_y_i,
  // result transaction
  output logic                                 valid_o,
  output logic                                 above_horizon_o,
  output logic                                 within_range_o,
  output logic signed [COORD_BITS-1:0]         ground_x_o,
  output logic signed [COORD_BITS-1:0]         ground_y_o,
  // register write transaction
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ppg_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ppg_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import ppg_pkg::*;

  localparam int unsigned DEN_W = ppg_den_w(PIXEL_BITS);
  localparam int unsigned NUM_W = ppg_num_w(PIXEL_BITS);
  localparam int unsigned QUO_W = ppg_quo_w(COORD_BITS);

  // Saturation bounds as magnitudes
  localparam logic [QUO_W-1:0] POS_MAX = QUO_W'((64'd1 << (COORD_BITS - 1)) - 1);
  localparam logic [QUO_W-1:0] NEG_MAX = QUO_W'(64'd1 << (COORD_BITS - 1));
  localparam logic [QUO_W-1:0] LIMIT   = QUO_W'(RANGE_LIMIT);

  ppg_cfg_t cfg_q;

  logic                    rot_vld, rot_above;
  logic signed [NUM_W-1:0] num_x, num_y;
  logic signed [DEN_W-1:0] den;

  logic             dx_vld, dx_tag, dx_neg, dx_ovf;
  logic             dy_vld, dy_tag, dy_neg, dy_ovf;
  logic [QUO_W-1:0] qx, qy;

  logic                         above_d, within_d, vld_d;
  logic signed [COORD_BITS-1:0] gx_d, gy_d;
  logic                         vld_q, above_q, within_q;
  logic signed [COORD_BITS-1:0] gx_q, gy_q;

  // The pipeline never stalls, so accept a pixel and a register write every cycle
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Register file: writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_x   <= ROT_X_RST;
      cfg_q.rot_y   <= ROT_Y_RST;
      cfg_q.rot_z   <= ROT_Z_RST;
      cfg_q.cam_pos <= CAM_POS_RST;
      cfg_q.opt_ctr <= OPT_CTR_RST;
      cfg_q.finv    <= FOC_INV_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ROT_X:   cfg_q.rot_x   <= cfg_data_i;
        REG_ROT_Y:   cfg_q.rot_y   <= cfg_data_i;
        REG_ROT_Z:   cfg_q.rot_z   <= cfg_data_i;
        REG_CAM_POS: cfg_q.cam_pos <= cfg_data_i;
        REG_OPT_CTR: cfg_q.opt_ctr <= cfg_data_i[31:0];
        REG_FOC_INV: cfg_q.finv    <= cfg_data_i[FINV_W-1:0];
        default: ;
      endcase
    end
  end

  // Ray, rotation, horizon test and numerators
  ppg_rotate #(
    .PIXEL_BITS (PIXEL_BITS),
    .DEN_W      (DEN_W),
    .NUM_W      (NUM_W)
  ) u_rotate (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (start && !busy),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .valid_o   (rot_vld),
    .above_o   (rot_above),
    .num_x_o   (num_x),
    .num_y_o   (num_y),
    .den_o     (den)
  );

  // Two dividers in lockstep; the horizon flag rides along as the tag
  ppg_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (QUO_W)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_vld),
    .tag_i   (rot_above),
    .num_i   (num_x),
    .den_i   (den),
    .valid_o (dx_vld),
    .tag_o   (dx_tag),
    .neg_o   (dx_neg),
    .ovf_o   (dx_ovf),
    .quo_o   (qx)
  );

  ppg_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (QUO_W)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_vld),
    .tag_i   (rot_above),
    .num_i   (num_y),
    .den_i   (den),
    .valid_o (dy_vld),
    .tag_o   (dy_tag),
    .neg_o   (dy_neg),
    .ovf_o   (dy_ovf),
    .quo_o   (qy)
  );

  // Output stage: range test on the unsaturated magnitude, then saturate
  assign vld_d    = dx_vld && dy_vld;
  assign above_d  = dx_tag || dy_tag;
  assign within_d = !above_d && !dx_ovf && !dy_ovf && (qx < LIMIT) && (qy < LIMIT);

  always_comb begin
    if (above_d) begin
      gx_d = '0;
    end else if (!dx_neg && (dx_ovf || (qx > POS_MAX))) begin
      gx_d = COORD_BITS'(POS_MAX);
    end else if (dx_neg && (dx_ovf || (qx > NEG_MAX))) begin
      gx_d = COORD_BITS'(NEG_MAX);
    end else if (dx_neg) begin
      gx_d = -COORD_BITS'(qx);
    end else begin
      gx_d = COORD_BITS'(qx);
    end

    if (above_d) begin
      gy_d = '0;
    end else if (!dy_neg && (dy_ovf || (qy > POS_MAX))) begin
      gy_d = COORD_BITS'(POS_MAX);
    end else if (dy_neg && (dy_ovf || (qy > NEG_MAX))) begin
      gy_d = COORD_BITS'(NEG_MAX);
    end else if (dy_neg) begin
      gy_d = -COORD_BITS'(qy);
    end else begin
      gy_d = COORD_BITS'(qy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    above_q  <= above_d;
    within_q <= within_d;
    gx_q     <= gx_d;
    gy_q     <= gy_d;
  end

  assign valid_o         = vld_q;
  assign above_horizon_o = above_q;
  assign within_range_o  = within_q;
  assign ground_x_o      = gx_q;
  assign ground_y_o      = gy_q;

endmodule

// File: bench/testbench.sv
// Self-checking bench for pixel_to_ground_projection: pixels in, ground points out.
// Predicts every result from a mirror of the camera registers and checks it in order.
// Depends on ppg_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
  import ppg_pkg::*;

  localparam int PB = 12;
  localparam int CB = 16;
  localparam int DRAIN_CYCLES = 40;      // drain margin beyond the pipeline depth
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [PB-1:0] px;
    logic [PB-1:0] py;
  } pixel_t;

  typedef struct {
    logic                 above;
    logic                 in_range;
    logic signed [CB-1:0] gx;
    logic signed [CB-1:0] gy;
  } ground_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [PB-1:0] pixel_x_i = '0;
  logic [PB-1:0] pixel_y_i = '0;
  logic valid_o, above_horizon_o, within_range_o;
  logic signed [CB-1:0] ground_x_o, ground_y_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  pixel_to_ground_projection #(.PIXEL_BITS(PB), .COORD_BITS(CB)) dut (.*);

  always #6 clk_i = ~clk_i;

  // Mirror of the camera registers, updated on every accepted register write.
  logic [47:0] rot_row[3];
  logic [47:0] cam_pos;
  logic [31:0] opt_ctr;
  logic [23:0] finv;

  pixel_t  pending_pixels[$];
  ground_t expected_points[$];
  pixel_t  cur_pixel;
  int      errors = 0;
  int      checked = 0;
  int      hits = 0;
  int      gap_left = 0;
  bit      idle_enable = 1'b1;
  longint  cycle_count = 0;

  function automatic longint entry_s16(logic [47:0] word, int pos);
    logic [15:0] v;
    v = word[pos +: 16];
    return longint'($signed(v));
  endfunction

  // Project one pixel onto the ground plane with the current register mirror.
  function automatic ground_t project_pixel(pixel_t p);
    ground_t r;
    longint cx, cy, f, v1, v2, w[3], lim, sx, sy, sz, tx, ty, tz, gx, gy;
    cx = longint'(opt_ctr[15:0]);
    cy = longint'(opt_ctr[31:16]);
    f  = longint'(finv);
    v1 = (cx - longint'(p.px) * 16) * f;
    v2 = (cy - longint'(p.py) * 16) * f;
    for (int i = 0; i < 3; i++)
      w[i] = entry_s16(rot_row[i], 0) * (longint'(1) << 28)
           + entry_s16(rot_row[i], 16) * v1 + entry_s16(rot_row[i], 32) * v2;
    lim = -f * 5 * (longint'(1) << 18);
    r = '{1'b1, 1'b0, '0, '0};
    if (w[2] > lim || w[2] == 0) return r;
    tx = entry_s16(cam_pos, 0);
    ty = entry_s16(cam_pos, 16);
    tz = entry_s16(cam_pos, 32);
    sx = w[0] >>> 16;   // arithmetic shift rounds toward minus infinity
    sy = w[1] >>> 16;
    sz = w[2] >>> 16;
    gx = (tx * sz - tz * sx) / sz;
    gy = (ty * sz - tz * sy) / sz;
    r.above    = 1'b0;
    r.in_range = (gx < 12764 && gx > -12764 && gy < 12764 && gy > -12764);
    r.gx = (gx > 32767) ? 16'sd32767 : (gx < -32768) ? -16'sd32768 : CB'(gx);
    r.gy = (gy > 32767) ? 16'sd32767 : (gy < -32768) ? -16'sd32768 : CB'(gy);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch #%0d on %s: got %0d expected %0d", checked, what, got, want);
    errors++;
  endtask

  // Driver: predict on every accepted pixel, then present the next one or idle.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (start && !busy) begin
      expected_points.insert(expected_points.size(), project_pixel(cur_pixel));
    end
    if (!start || !busy) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (idle_enable && pending_pixels.size() > 0 && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 12);
        start <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        cur_pixel = pending_pixels.pop_front();
        pixel_x_i <= cur_pixel.px;
        pixel_y_i <= cur_pixel.py;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each result strobe consumes the oldest prediction.
  always @(posedge clk_i) begin
    if (valid_o) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected result transaction", 1, 0);
      end else begin
        ground_t e;
        e = expected_points.pop_front();
        if (above_horizon_o !== e.above) report_mismatch("above_horizon", above_horizon_o, e.above);
        if (within_range_o !== e.in_range)
          report_mismatch("within_range", within_range_o, e.in_range);
        if (ground_x_o !== e.gx) report_mismatch("ground_x", ground_x_o, e.gx);
        if (ground_y_o !== e.gy) report_mismatch("ground_y", ground_y_o, e.gy);
        if (!e.above) hits++;
        checked++;
      end
    end
  end

  // Guard against a hang.
  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // One register write transaction; the mirror follows on acceptance.
  task automatic write_reg(cfg_reg_e idx, logic [47:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_ROT_X:   rot_row[0] = data;
      REG_ROT_Y:   rot_row[1] = data;
      REG_ROT_Z:   rot_row[2] = data;
      REG_CAM_POS: cam_pos = data;
      REG_OPT_CTR: opt_ctr = data[31:0];
      REG_FOC_INV: finv = data[23:0];
      default: ;
    endcase
  endtask

  // Hold the sender until the pipeline has fully drained.
  task automatic drain();
    wait (pending_pixels.size() == 0 && !start && expected_points.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  // Append one pixel to the pending list.
  task automatic queue_pixel(logic [PB-1:0] x, logic [PB-1:0] y);
    pixel_t p;
    p.px = x;
    p.py = y;
    pending_pixels.insert(pending_pixels.size(), p);
  endtask

  // Camera tilted down by a random amount, random position, realistic focal.
  task automatic tilted_camera();
    logic signed [15:0] c, s;
    c = 16'($urandom_range(9000, 16384));
    s = -$signed(16'($urandom_range(3000, 12000)));
    write_reg(REG_ROT_X, {-s, 16'sd0, c});
    write_reg(REG_ROT_Y, {16'd0, 16'sd16384, 16'd0});
    write_reg(REG_ROT_Z, {c, 16'sd0, s});
    write_reg(REG_CAM_POS, {16'($urandom_range(100, 2000)), 16'($urandom), 16'($urandom)});
    write_reg(REG_OPT_CTR, 48'({16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))}));
    write_reg(REG_FOC_INV, 48'($urandom_range(5000, 80000)));
  endtask

  task automatic random_pixels(int n, int lo, int hi);
    for (int i = 0; i < n; i++)
      queue_pixel(PB'($urandom_range(lo, hi)), PB'($urandom_range(lo, hi)));
  endtask

  initial begin
    rot_row[0] = ROT_X_RST;
    rot_row[1] = ROT_Y_RST;
    rot_row[2] = ROT_Z_RST;
    cam_pos = CAM_POS_RST;
    opt_ctr = OPT_CTR_RST;
    finv = FOC_INV_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset camera, image corners, optical center, rows around the horizon.
    queue_pixel(12'd0, 12'd0);
    queue_pixel(12'd4095, 12'd4095);
    queue_pixel(12'd0, 12'd4095);
    queue_pixel(12'd4095, 12'd0);
    queue_pixel(12'd320, 12'd240);
    queue_pixel(12'd320, 12'd241);
    queue_pixel(12'd320, 12'd245);
    queue_pixel(12'd320, 12'd246);
    queue_pixel(12'd320, 12'd250);
    queue_pixel(12'd2730, 12'd1365);
    queue_pixel(12'd1365, 12'd2730);
    queue_pixel(12'd0, 12'd480);
    drain();

    // Zero focal inverse gives zero world z; indexes past the list are ignored.
    write_reg(REG_FOC_INV, 48'd0);
    write_reg(cfg_reg_e'(3'd6), rand48());
    write_reg(cfg_reg_e'(3'd7), rand48());
    queue_pixel(12'd0, 12'd0);
    queue_pixel(12'd4095, 12'd4095);
    drain();

    // Extremes: register fields set to all ones or to their largest and smallest signed values, in two mixes.
    write_reg(REG_ROT_X, '1);
    write_reg(REG_ROT_Y, 48'h8000_7FFF_8000);
    write_reg(REG_ROT_Z, 48'h8000_8000_8000);
    write_reg(REG_CAM_POS, 48'h7FFF_8000_7FFF);
    write_reg(REG_OPT_CTR, '1);
    write_reg(REG_FOC_INV, '1);
    queue_pixel(12'd0, 12'd0);
    queue_pixel(12'd4095, 12'd4095);
    queue_pixel(12'd4095, 12'd0);
    random_pixels(4, 0, 4095);
    drain();
    write_reg(REG_ROT_Z, 48'h7FFF_7FFF_8000);
    write_reg(REG_OPT_CTR, '0);
    write_reg(REG_CAM_POS, 48'h8000_7FFF_8000);
    queue_pixel(12'd0, 12'd0);
    queue_pixel(12'd4095, 12'd4095);
    drain();

    // Random phases: mostly plausible tilted cameras, some fully random registers.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2) begin
        write_reg(REG_ROT_X, rand48());
        write_reg(REG_ROT_Y, rand48());
        write_reg(REG_ROT_Z, rand48());
        write_reg(REG_CAM_POS, rand48());
        write_reg(REG_OPT_CTR, {16'($urandom), $urandom});
        write_reg(REG_FOC_INV, 48'($urandom));
      end else begin
        tilted_camera();
      end
      if (ph == 7) idle_enable = 1'b0;   // last phase runs back to back
      random_pixels(100, 0, 4095);
      random_pixels(70, 0, 700);
      drain();
    end

    $display("checked %0d results, %0d of them ground hits, over %0d camera settings",
             checked, hits, 12);
    $display("covered reset camera, zero focal inverse, register extremes and random cameras");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
